/* sv/nearest_pitch_time_matcher_top_assert.svh */
// ----------------------------------------------------------------------------
// nearest_pitch_time_matcher_top_assert.svh
// Assertion macros for the nearest pitch/time matcher; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PITCH_TIME_MATCHER_TOP_ASSERT_SVH
`define NEAREST_PITCH_TIME_MATCHER_TOP_ASSERT_SVH

`ifndef SYNTH
// expression holds at every clock edge outside reset
`define NPT_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("npt assertion failed");
// antecedent implies consequent in the same cycle
`define NPT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("npt assertion failed");
`else
`define NPT_ASSERT_ALWAYS(lbl, expr)
`define NPT_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

/* sv/npt_pkg.sv */
// ----------------------------------------------------------------------------
// npt_pkg
// Shared widths, function codes and the scan packet of the pitch/time matcher.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int PITCH_W   = 7;
    localparam int TIME_W    = 32;
    localparam int CONF_W    = 16;
    localparam int FUNC_W    = 2;

    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

    // query packet walking down the cell row
    typedef struct packed {
        logic                     valid;
        logic [PITCH_W-1:0]       pitch;
        logic [TIME_W-1:0]        time_ms;
        logic [TIME_W-1:0]        best;
        logic                     found;
        logic signed [CONF_W-1:0] win;
    } t_pkt;

    // entry write broadcast to the cells
    typedef struct packed {
        logic                     en;
        logic [PITCH_W-1:0]       pitch;
        logic [TIME_W-1:0]        time_ms;
        logic signed [CONF_W-1:0] conf;
    } t_wr;

endpackage

/* sv/npt_cell.sv */
// ----------------------------------------------------------------------------
// npt_cell
// One table entry plus one stage of the query scan: compare, keep the closer.
// ----------------------------------------------------------------------------
module npt_cell #(
    parameter int IDX   = 0,
    parameter int AW    = 8,
    parameter int CW    = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  npt_pkg::t_wr  i_wr,
    input  logic [AW-1:0] i_waddr,
    input  logic [CW-1:0] i_count,
    input  npt_pkg::t_pkt i_pkt,
    output npt_pkg::t_pkt o_pkt
);
    import npt_pkg::*;

    localparam logic [AW-1:0] IDX_A = AW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [PITCH_W-1:0]       r_pitch;
    logic [TIME_W-1:0]        r_time;
    logic signed [CONF_W-1:0] r_conf;
    t_pkt                     r_pkt;
    t_pkt                     n_pkt;

    logic [TIME_W-1:0] w_dist;
    logic              w_take;

    always_comb begin
        if (r_time > i_pkt.time_ms) begin
            w_dist = r_time - i_pkt.time_ms;
        end else begin
            w_dist = i_pkt.time_ms - r_time;
        end
        // only loaded entries take part; ties go to the later cell
        w_take = i_pkt.valid && (IDX_C < i_count) && (r_pitch == i_pkt.pitch)
                 && (w_dist <= i_pkt.best);
        n_pkt = i_pkt;
        if (w_take) begin
            n_pkt.best  = w_dist;
            n_pkt.found = 1'b1;
            n_pkt.win   = r_conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_waddr == IDX_A)) begin
            r_pitch <= i_wr.pitch;
            r_time  <= i_wr.time_ms;
            r_conf  <= i_wr.conf;
        end
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

/* sv/nearest_pitch_time_matcher_top.sv */
// ----------------------------------------------------------------------------
// nearest_pitch_time_matcher_top
// Reference note table with nearest pitch/time lookup over a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries func, pitch, start_time and
//   conf_in. Every request gives exactly one result on the output channel
//   (o_out_valid/i_out_ready): matched, conf_out, match_count, table_full.
//   Clear, load and unused codes need no scan; the result is registered
//   on the next edge.
//   A query enters the first cell and moves one cell per cycle through the
//   TABLE_DEPTH cells; its result is registered as it leaves the last cell.
//   Only one query is in the cell row at a time.
//   Loads write the cell at the current entry count.
//   Tolerance is written through i_cfg_valid/o_cfg_ready (always ready);
//   the user writes it only while idle; the block does not enforce this.
//   Reset clears the entry count, the match total, and sets tolerance to 50;
//   table contents stay undefined until loaded, with no clearing pass.
//   A stalled receiver holds the result register; no new request is taken
//   until that result is taken or leaves in the same cycle.
// ----------------------------------------------------------------------------
`include "nearest_pitch_time_matcher_top_assert.svh"

module nearest_pitch_time_matcher_top #(
    parameter int TABLE_DEPTH = npt_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [npt_pkg::FUNC_W-1:0]       i_func,
    input  logic [npt_pkg::PITCH_W-1:0]      i_pitch,
    input  logic [npt_pkg::TIME_W-1:0]       i_start_time,
    input  logic signed [npt_pkg::CONF_W-1:0] i_conf_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_matched,
    output logic [14:0]                      o_conf_out,
    output logic [31:0]                      o_match_count,
    output logic                             o_table_full,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [31:0]                      i_cfg_tolerance
);
    import npt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [14:0]   Q_ONE   = 15'd16384;
    localparam logic [31:0]   TOL_RST = 32'd50;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_total, n_total;
    logic [31:0]   r_tol;
    logic          r_out_valid, n_out_valid;
    logic          r_matched, n_matched;
    logic [14:0]   r_conf_out, n_conf_out;
    logic [31:0]   r_mcount, n_mcount;
    logic          r_full, n_full;

    logic  w_acc;
    t_wr   w_wr;
    t_pkt  w_head;
    t_pkt  w_chain [0:TABLE_DEPTH];
    t_pkt  w_exit;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_exit      = w_chain[TABLE_DEPTH];
    assign w_chain[0]  = w_head;

    // inject the query at the head of the row and build the load write
    always_comb begin
        w_head.valid   = w_acc && (i_func == FN_QUERY);
        w_head.pitch   = i_pitch;
        w_head.time_ms = i_start_time;
        w_head.best    = r_tol;
        w_head.found   = 1'b0;
        w_head.win     = '0;
        w_wr.en      = w_acc && (i_func == FN_LOAD) && (r_count < DEPTH_C);
        w_wr.pitch   = i_pitch;
        w_wr.time_ms = i_start_time;
        w_wr.conf    = i_conf_in;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            npt_cell #(
                .IDX (g),
                .AW  (AW),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr    (w_wr),
                .i_waddr (r_count[AW-1:0]),
                .i_count (r_count),
                .i_pkt   (w_chain[g]),
                .o_pkt   (w_chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_matched   = r_matched;
        n_conf_out  = r_conf_out;
        n_mcount    = r_mcount;
        n_full      = r_full;
        if (w_acc) begin
            n_matched  = 1'b0;
            n_conf_out = '0;
            n_full     = 1'b0;
            n_mcount   = r_total;
            case (i_func)
                FN_CLEAR: begin
                    n_count     = '0;
                    n_total     = '0;
                    n_mcount    = '0;
                    n_out_valid = 1'b1;
                end
                FN_LOAD: begin
                    if (r_count < DEPTH_C) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_full = 1'b1;
                    end
                    n_out_valid = 1'b1;
                end
                FN_QUERY: begin
                    n_state = S_SCAN;
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
        end
        if (w_exit.valid) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_matched   = w_exit.found;
            n_full      = 1'b0;
            n_conf_out  = '0;
            n_mcount    = r_total;
            if (w_exit.found) begin
                // clamp Q2.14 confidence to 0..1
                if (w_exit.win[CONF_W-1]) begin
                    n_conf_out = '0;
                end else if (w_exit.win[14:0] > Q_ONE) begin
                    n_conf_out = Q_ONE;
                end else begin
                    n_conf_out = w_exit.win[14:0];
                end
                if (r_total != 32'hFFFF_FFFF) begin
                    n_total  = r_total + 32'd1;
                    n_mcount = r_total + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_tol       <= TOL_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_tol <= i_cfg_tolerance;
            end
        end
        r_matched  <= n_matched;
        r_conf_out <= n_conf_out;
        r_mcount   <= n_mcount;
        r_full     <= n_full;
    end

    assign o_out_valid   = r_out_valid;
    assign o_matched     = r_matched;
    assign o_conf_out    = r_conf_out;
    assign o_match_count = r_mcount;
    assign o_table_full  = r_full;

    `NPT_ASSERT_IMPL(a_no_accept_in_scan, r_state == S_SCAN, !o_in_ready)
    `NPT_ASSERT_IMPL(a_exit_only_in_scan, w_exit.valid, r_state == S_SCAN && !r_out_valid)
    `NPT_ASSERT_ALWAYS(a_count_bound, r_count <= DEPTH_C)
    `NPT_ASSERT_IMPL(a_nomatch_zero_conf, o_out_valid && !o_matched, o_conf_out == 15'd0)

endmodule
